/* design/countdown_timer_pool_unit_defines.svh */
// Assertion macros used by the countdown timer pool datapath.
`ifndef COUNTDOWN_TIMER_POOL_UNIT_DEFINES_SVH
`define COUNTDOWN_TIMER_POOL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CTP_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (prop)) else $error(msg);
`define CTP_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);
`else
`define CTP_ASSERT(lbl, c, r, prop, msg)
`define CTP_ASSERT_NEXT(lbl, c, r, ante, cons, msg)
`endif

`endif

/* design/ctp_pkg.sv */
// Types, codes and constants of the countdown timer pool.
package ctp_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RES        = 16;
  localparam int RES_CW         = $clog2(MAX_RES + 1);

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_EXPIRED   = 3'd1;
  localparam logic [2:0] EV_CANCELLED = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_ACK       = 3'd4;
  localparam logic [2:0] EV_IDLE      = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] duration;
    logic [3:0]  timer_id;
    logic [30:0] elapsed;
    logic [15:0] client_ready;
  } ctp_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] slot;
    logic       last;
  } ctp_out_t;

  typedef struct packed {
    logic load;
    logic single;
    logic alloc;
    logic tick_init;
    logic upd;
    logic fin;
  } ctp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       start_full;
    logic       walk_empty;
    logic       walk_last;
  } ctp_status_t;

endpackage

/* design/ctp_ctrl.sv */
// Sequencing state machine of the countdown timer pool.
module ctp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ctp_pkg::ctp_status_t sts,
  output ctp_pkg::ctp_cmd_t   cmd
);
  import ctp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_ALLOC  = 3'd2;
  localparam logic [2:0] ST_TORD   = 3'd3;
  localparam logic [2:0] ST_TREM   = 3'd4;
  localparam logic [2:0] ST_TUPD   = 3'd5;
  localparam logic [2:0] ST_TFIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.action)
          ACT_START: begin
            if (sts.start_full) begin
              cmd.single = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              // The free stack read is under way; the slot is taken next cycle.
              state_nxt = ST_ALLOC;
            end
          end
          ACT_CANCEL, ACT_RELEASE: begin
            cmd.single = 1'b1;
            state_nxt  = ST_IDLE;
          end
          ACT_TICK: begin
            cmd.tick_init = 1'b1;
            state_nxt     = sts.walk_empty ? ST_TFIN : ST_TORD;
          end
        endcase
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_TORD: state_nxt = ST_TREM;
      ST_TREM: state_nxt = ST_TUPD;
      ST_TUPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.walk_last ? ST_TFIN : ST_TORD;
      end
      ST_TFIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* design/ctp_datapath.sv */
// Timer storage, list bookkeeping and result staging of the countdown timer pool.
`include "countdown_timer_pool_unit_defines.svh"

module ctp_datapath #(
  parameter int NUM_TIMERS = ctp_pkg::NUM_TIMERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctp_pkg::ctp_in_t     in_item,
  input  ctp_pkg::ctp_cmd_t    cmd,
  output ctp_pkg::ctp_status_t sts,
  output logic                 out_valid,
  output ctp_pkg::ctp_out_t    out_item
);
  import ctp_pkg::*;

  localparam int SW    = $clog2(NUM_TIMERS);
  localparam int CW    = $clog2(NUM_TIMERS + 1);
  localparam int XW    = SW + 4;
  localparam int DEPTH = 1 << SW;

  ctp_in_t             item_r;
  logic [CW-1:0]       active_count_r;
  logic [CW-1:0]       free_count_r;
  logic [CW-1:0]       fresh_next_r;
  logic [NUM_TIMERS-1:0] cancel_r;
  logic [CW-1:0]       i_r;
  logic [CW-1:0]       w_r;
  logic [RES_CW-1:0]   n_r;
  ctp_out_t            pend_r;
  logic                pend_valid_r;
  ctp_out_t            out_r;
  logic                out_valid_r;

  logic [31:0]   rem_mem   [DEPTH];
  logic [SW-1:0] order_mem [DEPTH];
  logic [SW-1:0] fs_mem    [DEPTH];
  logic [31:0]   rem_rd_r;
  logic [SW-1:0] order_rd_r;
  logic [SW-1:0] fs_rd_r;

  logic          rem_we;
  logic [SW-1:0] rem_waddr;
  logic [31:0]   rem_wdata;
  logic          order_we;
  logic [SW-1:0] order_waddr;
  logic [SW-1:0] order_wdata;
  logic          fs_we;
  logic [SW-1:0] fs_waddr;
  logic [SW-1:0] fs_wdata;

  logic [CW-1:0] fc_m1;
  logic          use_free;
  logic          fs_room;
  logic [SW-1:0] s_alloc;
  logic [XW-1:0] s_alloc_x;
  logic [XW-1:0] tid_x;
  logic          tid_ok;
  logic [SW-1:0] s_cur;
  logic [XW-1:0] s_x;
  logic [32:0]   diff;
  logic [31:0]   v;
  logic          nonpos;
  logic          rdy;
  logic          can_emit;
  logic          is_cancel;
  logic          emit_now;
  logic          drop_cancel;
  logic          do_release;
  logic          out_set;
  ctp_out_t      out_nxt;
  ctp_out_t      pend_nxt;

  assign fc_m1     = free_count_r - CW'(1);
  assign use_free  = (free_count_r != '0);
  assign fs_room   = (free_count_r < CW'(NUM_TIMERS));
  assign s_alloc   = use_free ? fs_rd_r : fresh_next_r[SW-1:0];
  assign s_alloc_x = XW'(s_alloc);
  assign tid_x     = XW'(item_r.timer_id);
  assign tid_ok    = (tid_x < XW'(fresh_next_r));
  assign do_release = cmd.single && (item_r.action == ACT_RELEASE) && tid_ok && fs_room;

  // Tick arithmetic: signed remaining time minus elapsed, clamped at the negative bound.
  assign s_cur  = order_rd_r;
  assign s_x    = XW'(s_cur);
  assign diff   = {rem_rd_r[31], rem_rd_r} - {2'b00, item_r.elapsed};
  assign v      = (diff[32] && !diff[31]) ? 32'h8000_0000 : diff[31:0];
  assign nonpos = v[31] || (v == '0);
  // Only the sixteen lowest slots have a client-ready bit.
  assign rdy    = (s_x < XW'(16)) && item_r.client_ready[s_x[3:0]];

  assign can_emit    = (n_r < RES_CW'(MAX_RES));
  assign is_cancel   = cancel_r[s_cur];
  assign emit_now    = can_emit && (is_cancel || (nonpos && rdy));
  assign drop_cancel = can_emit && is_cancel;

  assign sts.action     = item_r.action;
  assign sts.start_full = (active_count_r >= CW'(NUM_TIMERS)) ||
                          (!use_free && (fresh_next_r >= CW'(NUM_TIMERS)));
  assign sts.walk_empty = (active_count_r == '0);
  assign sts.walk_last  = ((i_r + CW'(1)) == active_count_r);

  always_comb begin
    rem_we      = 1'b0;
    rem_waddr   = s_alloc;
    rem_wdata   = {1'b0, item_r.duration};
    order_we    = 1'b0;
    order_waddr = active_count_r[SW-1:0];
    order_wdata = s_alloc;
    fs_we       = 1'b0;
    fs_waddr    = free_count_r[SW-1:0];
    fs_wdata    = tid_x[SW-1:0];
    if (cmd.alloc) begin
      rem_we   = 1'b1;
      order_we = 1'b1;
    end else if (cmd.upd) begin
      rem_we      = 1'b1;
      rem_waddr   = s_cur;
      rem_wdata   = v;
      order_we    = !emit_now;
      order_waddr = w_r[SW-1:0];
      order_wdata = s_cur;
      fs_we       = drop_cancel && fs_room;
      fs_wdata    = s_cur;
    end else if (do_release) begin
      fs_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rem_rd_r <= rem_mem[order_rd_r];
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rd_r <= order_mem[i_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rd_r <= fs_mem[fc_m1[SW-1:0]];
  end

  // A tick holds back its newest result so that the final transfer can carry last.
  always_comb begin
    out_set  = 1'b0;
    out_nxt  = '0;
    pend_nxt = '0;
    pend_nxt.event_res = is_cancel ? EV_CANCELLED : EV_EXPIRED;
    pend_nxt.slot      = s_x[3:0];
    if (cmd.single) begin
      out_nxt.last = 1'b1;
      unique case (item_r.action)
        ACT_START: begin
          out_set           = 1'b1;
          out_nxt.event_res = EV_FULL;
        end
        ACT_CANCEL, ACT_RELEASE: begin
          out_set           = 1'b1;
          out_nxt.event_res = EV_ACK;
          out_nxt.slot      = item_r.timer_id;
        end
        ACT_TICK: out_set = 1'b0;
      endcase
    end else if (cmd.alloc) begin
      out_set           = 1'b1;
      out_nxt.event_res = EV_STARTED;
      out_nxt.slot      = s_alloc_x[3:0];
      out_nxt.last      = 1'b1;
    end else if (cmd.upd) begin
      out_set = emit_now && pend_valid_r;
      out_nxt = pend_r;
    end else if (cmd.fin) begin
      out_set = 1'b1;
      if (pend_valid_r) begin
        out_nxt = pend_r;
      end else begin
        out_nxt.event_res = EV_IDLE;
      end
      out_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.upd && emit_now) begin
      pend_r <= pend_nxt;
    end
    if (out_set) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= '0;
      free_count_r   <= '0;
      fresh_next_r   <= '0;
      cancel_r       <= '0;
      i_r            <= '0;
      w_r            <= '0;
      n_r            <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_set;
      if (cmd.single) begin
        if ((item_r.action == ACT_CANCEL) && tid_ok) begin
          cancel_r[tid_x[SW-1:0]] <= 1'b1;
        end
        if (do_release) begin
          free_count_r <= free_count_r + CW'(1);
        end
      end
      if (cmd.alloc) begin
        cancel_r[s_alloc] <= 1'b0;
        active_count_r    <= active_count_r + CW'(1);
        if (use_free) begin
          free_count_r <= fc_m1;
        end else begin
          fresh_next_r <= fresh_next_r + CW'(1);
        end
      end
      if (cmd.tick_init) begin
        i_r          <= '0;
        w_r          <= '0;
        n_r          <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.upd) begin
        i_r <= i_r + CW'(1);
        if (!emit_now) begin
          w_r <= w_r + CW'(1);
        end else begin
          n_r          <= n_r + RES_CW'(1);
          pend_valid_r <= 1'b1;
        end
        if (drop_cancel && fs_room) begin
          free_count_r <= free_count_r + CW'(1);
        end
      end
      if (cmd.fin) begin
        active_count_r <= w_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CTP_ASSERT(a_active_bound, clk, rst_n, active_count_r <= CW'(NUM_TIMERS), "active count exceeds pool")
  `CTP_ASSERT(a_walk_order, clk, rst_n, w_r <= i_r, "list write index passed read index")
  `CTP_ASSERT(a_res_bound, clk, rst_n, n_r <= RES_CW'(MAX_RES), "too many tick results")
  `CTP_ASSERT_NEXT(a_fin_strobe, clk, rst_n, cmd.fin, out_valid_r, "tick ended without a final result")

endmodule

/* design/countdown_timer_pool_unit.sv */
// Cancel, release and a refused start give their one result from the decode state; a granted
// start gives its result from the allocate state. A tick walks its active list entry by entry
// (order read, time read, update for each entry) and ends with a final result.
// busy stays high until the final result is registered; results cannot be stalled.
// Reset (rst_n low, synchronous) empties the pool and clears cancel marks; timer, list and
// free stack memories are not cleared, and no clearing pass follows reset.
module countdown_timer_pool_unit #(
  parameter int NUM_TIMERS = ctp_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ctp_pkg::ctp_in_t  in_item,
  output logic              out_valid,
  output ctp_pkg::ctp_out_t out_item
);
  import ctp_pkg::*;

  ctp_cmd_t    cmd;
  ctp_status_t sts;

  ctp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ctp_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* bench/countdown_timer_pool_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the countdown timer pool: predicts the events of each transfer and checks results.
module countdown_timer_pool_checker #(
  parameter int NUM_TIMERS = ctp_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ctp_pkg::ctp_in_t  in_item,
  input  logic              out_valid,
  input  ctp_pkg::ctp_out_t out_item,
  output int                fail_count,
  output int                pending_count
);
  import ctp_pkg::*;

  localparam longint TIME_FLOOR = 64'shFFFF_FFFF_8000_0000;

  // Shadow copy of the pool.
  int       time_left   [NUM_TIMERS];
  bit       cancel_flag [NUM_TIMERS];
  int       run_list    [NUM_TIMERS];
  int       run_count;
  int       spare_stack [NUM_TIMERS];
  int       spare_count;
  int       next_fresh;
  ctp_out_t expected_events[$];

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void queue_event(input logic [2:0] ev, input int s);
    ctp_out_t e;
    e.event_res = ev;
    e.slot      = s[3:0];
    e.last      = 1'b0;
    expected_events.push_back(e);
  endfunction

  function automatic void push_spare(input int s);
    if (spare_count < NUM_TIMERS) begin
      spare_stack[spare_count] = s;
      spare_count++;
    end
  endfunction

  task automatic predict_timer_events(input ctp_in_t it);
    int       s;
    int       i;
    int       w;
    int       emitted;
    longint   v;
    bit       drop;
    ctp_out_t tail;
    emitted = 0;
    case (it.action)
      ACT_START: begin
        if (run_count < NUM_TIMERS && (spare_count > 0 || next_fresh < NUM_TIMERS)) begin
          if (spare_count > 0) begin
            spare_count--;
            s = spare_stack[spare_count];
          end else begin
            s = next_fresh;
            next_fresh++;
          end
          time_left[s]        = {1'b0, it.duration};
          cancel_flag[s]      = 1'b0;
          run_list[run_count] = s;
          run_count++;
          queue_event(EV_STARTED, s);
        end else begin
          queue_event(EV_FULL, 0);
        end
      end
      ACT_CANCEL: begin
        if (int'(it.timer_id) < next_fresh) cancel_flag[it.timer_id] = 1'b1;
        queue_event(EV_ACK, int'(it.timer_id));
      end
      ACT_RELEASE: begin
        if (int'(it.timer_id) < next_fresh) push_spare(int'(it.timer_id));
        queue_event(EV_ACK, int'(it.timer_id));
      end
      ACT_TICK: begin
        w = 0;
        for (i = 0; i < run_count; i++) begin
          s    = run_list[i];
          drop = 1'b0;
          v    = longint'(time_left[s]) - longint'({1'b0, it.elapsed});
          if (v < TIME_FLOOR) v = TIME_FLOOR;
          time_left[s] = int'(v);
          // Once the result budget is spent, entries are only counted down.
          if (emitted < MAX_RES) begin
            if (cancel_flag[s]) begin
              push_spare(s);
              queue_event(EV_CANCELLED, s);
              emitted++;
              drop = 1'b1;
            end else if (v <= 0 && s < 16 && it.client_ready[s]) begin
              queue_event(EV_EXPIRED, s);
              emitted++;
              drop = 1'b1;
            end
          end
          if (!drop) begin
            run_list[w] = s;
            w++;
          end
        end
        run_count = w;
        if (emitted == 0) queue_event(EV_IDLE, 0);
      end
    endcase
    tail      = expected_events.pop_back();
    tail.last = 1'b1;
    expected_events.push_back(tail);
  endtask

  task automatic check_result(input ctp_out_t got);
    ctp_out_t want;
    if (expected_events.size() == 0) begin
      flag_error($sformatf("result with nothing pending: event %0d slot %0d last %0d",
                           got.event_res, got.slot, got.last));
      return;
    end
    want = expected_events.pop_front();
    if (got.event_res !== want.event_res)
      flag_error($sformatf("event_res %0d, predicted %0d (slot %0d)",
                           got.event_res, want.event_res, want.slot));
    if (got.slot !== want.slot)
      flag_error($sformatf("slot %0d, predicted %0d (event %0d)",
                           got.slot, want.slot, want.event_res));
    if (got.last !== want.last)
      flag_error($sformatf("last %0d, predicted %0d (event %0d slot %0d)",
                           got.last, want.last, want.event_res, want.slot));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TIMERS; k++) cancel_flag[k] = 1'b0;
      run_count   = 0;
      spare_count = 0;
      next_fresh  = 0;
      fail_count  = 0;
      expected_events.delete();
    end else begin
      // A transfer can share an edge with the previous item's final result; the new
      // events go to the back of the queue, so predicting first keeps the order.
      if (start && !busy) predict_timer_events(in_item);
      if (out_valid) check_result(out_item);
    end
    pending_count = expected_events.size();
  end

endmodule

/* bench/countdown_timer_pool_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the countdown timer pool testbench: clock, reset, command stimulus and verdict.
module countdown_timer_pool_unit_tb;
  import ctp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEM_TARGET  = 105;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ctp_in_t  in_item;
  logic     out_valid;
  ctp_out_t out_item;
  int       fail_count;
  int       pending_count;
  int       cycle_count = 0;
  int       burst_left  = 0;
  int       items_sent  = 0;

  countdown_timer_pool_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  countdown_timer_pool_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic ctp_in_t noise_item();
    ctp_in_t it;
    it.action       = 2'($urandom_range(0, 3));
    it.duration     = 31'($urandom);
    it.timer_id     = 4'($urandom_range(0, 15));
    it.elapsed      = 31'($urandom);
    it.client_ready = 16'($urandom);
    return it;
  endfunction

  // Mostly short countdowns so that timers actually expire during the run.
  function automatic logic [30:0] pick_ms(input int short_max);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 31'($urandom);
    if (r == 1) return 31'd0;
    return 31'($urandom_range(0, short_max));
  endfunction

  // Sender works in bursts; between bursts start is held low for a random gap.
  task automatic send_item(input ctp_in_t it);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0:       gap = 0;
        1:       gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 8);
      endcase
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        in_item <= noise_item();
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] act, input logic [30:0] dur,
                          input logic [3:0] tid, input logic [30:0] ela,
                          input logic [15:0] rdy);
    ctp_in_t it;
    it.action       = act;
    it.duration     = dur;
    it.timer_id     = tid;
    it.elapsed      = ela;
    it.client_ready = rdy;
    send_item(it);
  endtask

  initial begin
    int n;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, commands on slots never handed out, saturation,
    // cancel versus expiry, release of a slot that is still running.
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'd7,          16'hFFFF);
    send_cmd(ACT_CANCEL,  31'd0,          4'd5,  31'd0,          16'h0000);
    send_cmd(ACT_RELEASE, 31'd0,          4'd15, 31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd0,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'h7FFF_FFFF,  4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd10,         4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd5,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_CANCEL,  31'd0,          4'd2,  31'd0,          16'h0000);
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'h7FFF_FFFF,  16'h0002);
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'h7FFF_FFFF,  16'h0000);
    send_cmd(ACT_RELEASE, 31'd0,          4'd1,  31'd0,          16'h0000);
    send_cmd(ACT_RELEASE, 31'd0,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd3,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'd3,          16'hFFFF);
    send_cmd(ACT_CANCEL,  31'd0,          4'd3,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd20,         4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_START,   31'd1,          4'd0,  31'd0,          16'h0000);
    send_cmd(ACT_TICK,    31'd0,          4'd0,  31'd30,         16'h8001);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // A client session: start some timers, tick them down, release a few slots.
          n = $urandom_range(1, 5);
          repeat (n) send_cmd(ACT_START, pick_ms(120), 4'($urandom), 31'($urandom),
                              16'($urandom));
          n = $urandom_range(1, 4);
          repeat (n) send_cmd(ACT_TICK, 31'($urandom), 4'($urandom), pick_ms(50),
                              ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'hFFFF);
          n = $urandom_range(0, 2);
          repeat (n) send_cmd(ACT_RELEASE, 31'($urandom), 4'($urandom_range(0, 15)),
                              31'($urandom), 16'($urandom));
        end
        5: begin
          // Run the pool dry so that starts get refused.
          repeat (18) send_cmd(ACT_START, pick_ms(300), 4'($urandom), 31'($urandom),
                               16'($urandom));
        end
        6: begin
          n = $urandom_range(1, 3);
          repeat (n) send_cmd(ACT_CANCEL, 31'($urandom), 4'($urandom_range(0, 15)),
                              31'($urandom), 16'($urandom));
          send_cmd(ACT_TICK, 31'($urandom), 4'($urandom), pick_ms(20), 16'($urandom));
        end
        7: begin
          n = $urandom_range(1, 3);
          repeat (n) send_cmd(ACT_RELEASE, 31'($urandom), 4'($urandom_range(0, 15)),
                              31'($urandom), 16'($urandom));
        end
        8: begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(noise_item());
        end
        default: begin
          // Let everything expire and hand the slots back.
          send_cmd(ACT_TICK, 31'($urandom), 4'($urandom), 31'($urandom), 16'hFFFF);
          n = $urandom_range(2, 6);
          repeat (n) send_cmd(ACT_RELEASE, 31'($urandom), 4'($urandom_range(0, 15)),
                              31'($urandom), 16'($urandom));
        end
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ctp_pkg.sv
design/ctp_ctrl.sv
design/ctp_datapath.sv
design/countdown_timer_pool_unit.sv
bench/countdown_timer_pool_checker.sv
bench/countdown_timer_pool_unit_tb.sv
